>>> rtl/cit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_pkg
// Shared types and constants for the connection id table.
// ----------------------------------------------------------------------------
package cit_pkg;

  // table geometry
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HANDLE_W = 16;
  localparam int NODE_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;

  // stream word widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 3'd0,
    CMD_REM_HANDLE = 3'd1,
    CMD_REM_NODE   = 3'd2,
    CMD_CHECK      = 3'd3,
    CMD_LOOKUP     = 3'd4
  } cmd_t;

  // status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_ID_DUP    = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_HDL_DUP   = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture input word, restart scan
    logic scan;    // step one entry
    logic commit;  // update table, load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current entry is the last one
    logic out_busy;   // output register holds a word not taken this cycle
  } dp_status_t;

endpackage

>>> rtl/cit_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_ctrl
// Command sequencer: accept, scan all entries, then commit the result.
// ----------------------------------------------------------------------------
module cit_ctrl import cit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t dp_sts,
  output dp_cmd_t    dp_cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    dp_cmd.load   = 1'b0;
    dp_cmd.scan   = 1'b0;
    dp_cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        dp_cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_sts.scan_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait until the output register can take the result
        if (!dp_sts.out_busy) begin
          dp_cmd.commit = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/cit_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cit_datapath
// Entry storage, scan compare logic, result decision and output register.
// ----------------------------------------------------------------------------
module cit_datapath import cit_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               dp_cmd,
  output dp_status_t            dp_sts,
  input  logic [CMD_W-1:0]      cmd_in,
  input  logic [HANDLE_W-1:0]   handle_in,
  input  logic [NODE_W-1:0]     node_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status_out,
  output logic                  found_out,
  output logic [HANDLE_W-1:0]   handle_out
);

  // table storage
  logic [ENTRIES-1:0]  valid_r;
  logic [HANDLE_W-1:0] handle_mem_r [ENTRIES];
  logic [NODE_W-1:0]   node_mem_r   [ENTRIES];

  // captured command word
  logic [CMD_W-1:0]    cmd_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [NODE_W-1:0]   node_r;

  // scan state
  logic [IDX_W-1:0]    scan_idx_r;   // read address
  logic [IDX_W-1:0]    cmp_idx_r;    // entry at the compare stage
  logic                cmp_vld_r;    // compare stage holds read data
  logic [HANDLE_W-1:0] rd_handle_r;
  logic [NODE_W-1:0]   rd_node_r;
  logic                node_hit_r, hdl_hit_r, free_hit_r;
  logic [IDX_W-1:0]    node_idx_r, hdl_idx_r, free_idx_r;
  logic [HANDLE_W-1:0] node_hdl_r;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic                found_r;
  logic [HANDLE_W-1:0] hout_r;

  logic                ent_valid, node_eq, hdl_eq, cmp_en;
  logic [HANDLE_W-1:0] ent_handle;

  // registered table read at the scan address
  always_ff @(posedge clk) begin
    rd_handle_r <= handle_mem_r[scan_idx_r];
    rd_node_r   <= node_mem_r[scan_idx_r];
  end

  // compare at the entry one behind the read address
  always_comb begin
    ent_valid  = valid_r[cmp_idx_r];
    ent_handle = rd_handle_r;
    node_eq    = ent_valid && (rd_node_r == node_r);
    hdl_eq     = ent_valid && (ent_handle == hdl_r);
    cmp_en     = dp_cmd.scan && cmp_vld_r;
  end

  assign dp_sts.scan_last = cmp_vld_r && (cmp_idx_r == IDX_W'(ENTRIES - 1));
  assign dp_sts.out_busy  = out_valid_r && !out_ready;

  // capture and scan, keep first hit of each kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cmp_idx_r  <= '0;
      cmp_vld_r  <= 1'b0;
      node_hit_r <= 1'b0;
      hdl_hit_r  <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (dp_cmd.load) begin
      scan_idx_r <= '0;
      cmp_idx_r  <= '0;
      cmp_vld_r  <= 1'b0;
      node_hit_r <= 1'b0;
      hdl_hit_r  <= 1'b0;
      free_hit_r <= 1'b0;
    end else if (dp_cmd.scan) begin
      // address stops at the last entry while the compare catches up
      if (scan_idx_r != IDX_W'(ENTRIES - 1)) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      cmp_idx_r <= scan_idx_r;
      cmp_vld_r <= 1'b1;
      if (cmp_en && !node_hit_r && node_eq) begin
        node_hit_r <= 1'b1;
      end
      if (cmp_en && !hdl_hit_r && hdl_eq) begin
        hdl_hit_r <= 1'b1;
      end
      if (cmp_en && !free_hit_r && !ent_valid) begin
        free_hit_r <= 1'b1;
      end
    end
  end

  // payload side of the scan
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r  <= cmd_in;
      hdl_r  <= handle_in;
      node_r <= node_in;
    end
    if (cmp_en) begin
      if (!node_hit_r && node_eq) begin
        node_idx_r <= cmp_idx_r;
        node_hdl_r <= ent_handle;
      end
      if (!hdl_hit_r && hdl_eq) begin
        hdl_idx_r <= cmp_idx_r;
      end
      if (!free_hit_r && !ent_valid) begin
        free_idx_r <= cmp_idx_r;
      end
    end
  end

  // result decision
  logic                wr_en, clr_en;
  logic [IDX_W-1:0]    clr_idx;
  logic [STATUS_W-1:0] status_nxt;
  logic                found_nxt;
  logic [HANDLE_W-1:0] hout_nxt;

  always_comb begin
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    clr_idx    = node_idx_r;
    status_nxt = STS_OK;
    found_nxt  = 1'b0;
    hout_nxt   = '0;
    unique case (cmd_r)
      CMD_REGISTER: begin
        priority if (node_hit_r) begin
          status_nxt = STS_ID_DUP;
        end else if (hdl_hit_r) begin
          status_nxt = STS_HDL_DUP;
        end else if (!free_hit_r) begin
          status_nxt = STS_FULL;
        end else begin
          wr_en = 1'b1;
        end
      end
      CMD_REM_HANDLE: begin
        clr_idx = hdl_idx_r;
        if (hdl_hit_r) begin
          clr_en = 1'b1;
        end else begin
          status_nxt = STS_NOT_FOUND;
        end
      end
      CMD_REM_NODE: begin
        if (node_hit_r) begin
          clr_en = 1'b1;
        end else begin
          status_nxt = STS_NOT_FOUND;
        end
      end
      CMD_CHECK: begin
        if (node_hit_r) begin
          found_nxt = 1'b1;
        end else begin
          status_nxt = STS_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        if (node_hit_r) begin
          found_nxt = 1'b1;
          hout_nxt  = node_hdl_r;
        end else begin
          status_nxt = STS_NOT_FOUND;
        end
      end
      default: begin
        // unused codes: no table change, status ok
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (dp_cmd.commit) begin
      if (wr_en) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && wr_en) begin
      handle_mem_r[free_idx_r] <= hdl_r;
      node_mem_r[free_idx_r]   <= node_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      hout_r   <= hout_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign status_out = status_r;
  assign found_out  = found_r;
  assign handle_out = hout_r;

endmodule

>>> rtl/connection_id_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_id_table_core
// Table of connection handle / node id pairs with register, remove, check
// and lookup commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the command, in_tdata the client handle
//   and node id. Each accepted word produces exactly one output word with
//   status, found flag and handle.
//   Each command walks all ENTRIES slots one per cycle through a single
//   compare unit behind a registered table read. A word passes through an
//   accept step, the scan of all entries and a commit step before its
//   result is loaded into the output register; a new word is accepted in
//   the cycle after the commit. No new word is taken before the previous
//   one has been committed.
//   Lowest-indexed matches win; register fills the lowest free slot.
//   Reset (rst_n low, synchronous) clears all valid bits and the output
//   valid flag; the table is usable on the next cycle.
//   If out_tready is low, the result waits in the output register. The
//   next word is still accepted and scanned; it holds in its commit step
//   until the previous result has been taken.
// ----------------------------------------------------------------------------
module connection_id_table_core import cit_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] client_handle, [47:16] node_id
  input  logic [CMD_W-1:0]      in_tuser,   // [2:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [2:0] status, [3] found,
                                            // [19:4] handle_out, [23:20] zero
);

  dp_cmd_t             dp_cmd;
  dp_status_t          dp_sts;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [HANDLE_W-1:0] handle_out;

  // sequencer
  cit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_sts    (dp_sts),
    .dp_cmd    (dp_cmd)
  );

  // storage and compare
  cit_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .dp_sts     (dp_sts),
    .cmd_in     (in_tuser),
    .handle_in  (in_tdata[HANDLE_W-1:0]),
    .node_in    (in_tdata[HANDLE_W +: NODE_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .status_out (status),
    .found_out  (found),
    .handle_out (handle_out)
  );

  // pack result word
  assign out_tdata = {4'b0000, handle_out, found, status};

endmodule
